### rtl/core/mar_pkg.sv
// Package: shared widths, limits and the sequencer state type of the agreement ratio block.
`default_nettype none

package mar_pkg;

   // Word and field widths
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned TOTAL_W  = 17;
   localparam int unsigned SUM_W    = TOTAL_W + 1;
   localparam int unsigned FRAC_W   = 16;

   // Longest pattern set expected; sets the saturation point of the totals
   localparam int unsigned MAX_WORDS = 1024;
   localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
   localparam longint unsigned TOTAL_RAW = longint'(MAX_WORDS) * longint'(WORD_W);
   localparam logic [TOTAL_W-1:0] TOTAL_LIMIT =
      (TOTAL_RAW > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(TOTAL_RAW);

   // Ratio of one in Q1.16
   localparam logic [TOTAL_W-1:0] RATIO_ONE = TOTAL_W'(64'd1 << FRAC_W);

   // Serial popcount: chunk width and chunks per word
   localparam int unsigned CHUNK_W = 8;
   localparam int unsigned CHUNKS  = WORD_W / CHUNK_W;
   localparam int unsigned POP_W   = $clog2(CHUNK_W + 1);

   // Restoring division: one quotient bit per step
   localparam int unsigned DIV_STEPS = FRAC_W + 1;
   localparam int unsigned STEP_W    = $clog2(((CHUNKS > DIV_STEPS) ? CHUNKS : DIV_STEPS) + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage : mar_pkg

`default_nettype wire

### rtl/core/mar_req_if.sv
// Interface: input channel carrying one simulation word of each of the four signals.
`default_nettype none

interface mar_req_if;
   logic                            valid;
   logic                            ready;
   logic [mar_pkg::WORD_W-1:0]      old_out_word;
   logic [mar_pkg::WORD_W-1:0]      new_out_word;
   logic [mar_pkg::WORD_W-1:0]      old_gate_word;
   logic [mar_pkg::WORD_W-1:0]      new_gate_word;
   logic                            last_word;

   modport source (
      output valid, old_out_word, new_out_word, old_gate_word, new_gate_word, last_word,
      input  ready
   );
   modport sink (
      input  valid, old_out_word, new_out_word, old_gate_word, new_gate_word, last_word,
      output ready
   );
endinterface : mar_req_if

`default_nettype wire

### rtl/core/mar_rsp_if.sv
// Interface: result channel carrying the totals and their ratio.
`default_nettype none

interface mar_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mar_pkg::TOTAL_W-1:0]     similarity;
   logic                            undefined;
   logic [mar_pkg::TOTAL_W-1:0]     good_total_out;
   logic [mar_pkg::TOTAL_W-1:0]     same_total_out;

   modport source (
      output valid, similarity, undefined, good_total_out, same_total_out,
      input  ready
   );
   modport sink (
      input  valid, similarity, undefined, good_total_out, same_total_out,
      output ready
   );
endinterface : mar_rsp_if

`default_nettype wire

### rtl/core/masked_agreement_ratio.sv
// Top level: masked popcount agreement totals with a serial ratio divider.
`default_nettype none

// Each accepted transaction carries four 64-bit simulation words. The good mask
// (outputs agree) and the same mask (gates agree inside the good mask) are
// counted 8 bits per cycle by one popcount and saturating-add unit per mask.
// On the word marked last a restoring divider forms same/good as Q1.16, one
// quotient bit per cycle, and the result is then handed to the output register.
// The result sits in its own output register, so the next word is accepted
// while a result still waits on rsp_chan. Totals saturate at 65536
// (MAX_WORDS * 64, capped at 17 bits) and are cleared once the result is
// loaded. A zero good total raises undefined and gives a similarity of 0.
module masked_agreement_ratio (
   input  wire logic  clock,
   input  wire logic  reset,
   mar_req_if.sink    req_chan,
   mar_rsp_if.source  rsp_chan
);

   // Sequencer and datapath registers
   mar_pkg::state_type                  state_ff, state_in;
   logic [mar_pkg::STEP_W-1:0]          step_ff, step_in;
   logic [mar_pkg::WORD_W-1:0]          gmask_ff, gmask_in;
   logic [mar_pkg::WORD_W-1:0]          smask_ff, smask_in;
   logic                                last_ff, last_in;
   logic [mar_pkg::TOTAL_W-1:0]         good_total_ff, good_total_in;
   logic [mar_pkg::TOTAL_W-1:0]         same_total_ff, same_total_in;
   logic [mar_pkg::SUM_W-1:0]           rem_ff, rem_in;
   logic [mar_pkg::TOTAL_W-1:0]         quo_ff, quo_in;

   // Output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mar_pkg::TOTAL_W-1:0]         rsp_sim_ff, rsp_sim_in;
   logic                                rsp_undef_ff, rsp_undef_in;
   logic [mar_pkg::TOTAL_W-1:0]         rsp_good_ff, rsp_good_in;
   logic [mar_pkg::TOTAL_W-1:0]         rsp_same_ff, rsp_same_in;

   logic                                req_take;
   logic                                out_free;
   logic                                count_end;
   logic                                div_end;
   logic [mar_pkg::POP_W-1:0]           good_pop;
   logic [mar_pkg::POP_W-1:0]           same_pop;
   logic [mar_pkg::SUM_W-1:0]           div_sub;
   logic                                div_ge;
   logic [mar_pkg::SUM_W-1:0]           div_rem;

   // Popcount of one chunk
   function automatic logic [mar_pkg::POP_W-1:0] pop_chunk(
      input logic [mar_pkg::CHUNK_W-1:0] bits
   );
      logic [mar_pkg::POP_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < int'(mar_pkg::CHUNK_W); i++) begin
         acc = acc + mar_pkg::POP_W'(bits[i]);
      end
      return acc;
   endfunction

   // Saturating add of a chunk count into a total
   function automatic logic [mar_pkg::TOTAL_W-1:0] sat_add(
      input logic [mar_pkg::TOTAL_W-1:0] total,
      input logic [mar_pkg::POP_W-1:0]   add
   );
      logic [mar_pkg::SUM_W-1:0] sum;
      sum = {1'b0, total} + mar_pkg::SUM_W'(add);
      if (sum > {1'b0, mar_pkg::TOTAL_LIMIT}) begin
         return mar_pkg::TOTAL_LIMIT;
      end
      return sum[mar_pkg::TOTAL_W-1:0];
   endfunction

   // Handshake terms
   assign req_take  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign count_end = (step_ff == mar_pkg::STEP_W'(mar_pkg::CHUNKS - 1));
   assign div_end   = (step_ff == mar_pkg::STEP_W'(mar_pkg::DIV_STEPS - 1));

   // Popcount of the low chunk of each mask
   assign good_pop = pop_chunk(gmask_ff[mar_pkg::CHUNK_W-1:0]);
   assign same_pop = pop_chunk(smask_ff[mar_pkg::CHUNK_W-1:0]);

   // Compare-subtract step of the divider
   assign div_sub = rem_ff - {1'b0, good_total_ff};
   assign div_ge  = (rem_ff >= {1'b0, good_total_ff});
   assign div_rem = div_ge ? div_sub : rem_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mar_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = mar_pkg::ST_COUNT;
            end
         end
         mar_pkg::ST_COUNT: begin
            if (count_end) begin
               state_in = last_ff ? mar_pkg::ST_DIV : mar_pkg::ST_IDLE;
            end
         end
         mar_pkg::ST_DIV: begin
            if (div_end) begin
               state_in = mar_pkg::ST_DONE;
            end
         end
         mar_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mar_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      req_chan.ready = (state_ff == mar_pkg::ST_IDLE);
      step_in        = step_ff;
      gmask_in       = gmask_ff;
      smask_in       = smask_ff;
      last_in        = last_ff;
      good_total_in  = good_total_ff;
      same_total_in  = same_total_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_sim_in     = rsp_sim_ff;
      rsp_undef_in   = rsp_undef_ff;
      rsp_good_in    = rsp_good_ff;
      rsp_same_in    = rsp_same_ff;
      case (state_ff)
         mar_pkg::ST_IDLE: begin
            // Form both masks at acceptance
            if (req_take) begin
               gmask_in = ~(req_chan.old_out_word ^ req_chan.new_out_word);
               smask_in = ~(req_chan.old_gate_word ^ req_chan.new_gate_word)
                        & ~(req_chan.old_out_word ^ req_chan.new_out_word);
               last_in  = req_chan.last_word;
               step_in  = '0;
            end
         end
         mar_pkg::ST_COUNT: begin
            // One chunk per cycle into the saturating totals
            good_total_in = sat_add(good_total_ff, good_pop);
            same_total_in = sat_add(same_total_ff, same_pop);
            gmask_in      = gmask_ff >> mar_pkg::CHUNK_W;
            smask_in      = smask_ff >> mar_pkg::CHUNK_W;
            if (count_end) begin
               step_in = '0;
               // Same total never exceeds good, so the integer quotient bit is the first step
               rem_in  = {1'b0, sat_add(same_total_ff, same_pop)};
               quo_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         mar_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle
            rem_in  = {div_rem[mar_pkg::SUM_W-2:0], 1'b0};
            quo_in  = {quo_ff[mar_pkg::TOTAL_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
         end
         mar_pkg::ST_DONE: begin
            // Hand the result over and clear the totals
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_undef_in  = (good_total_ff == '0);
               rsp_sim_in    = (good_total_ff == '0) ? '0 : quo_ff;
               rsp_good_in   = good_total_ff;
               rsp_same_in   = same_total_ff;
               good_total_in = '0;
               same_total_in = '0;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mar_pkg::ST_IDLE;
         step_ff       <= '0;
         good_total_ff <= '0;
         same_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         good_total_ff <= good_total_in;
         same_total_ff <= same_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      gmask_ff     <= gmask_in;
      smask_ff     <= smask_in;
      last_ff      <= last_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_sim_ff   <= rsp_sim_in;
      rsp_undef_ff <= rsp_undef_in;
      rsp_good_ff  <= rsp_good_in;
      rsp_same_ff  <= rsp_same_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.similarity     = rsp_sim_ff;
   assign rsp_chan.undefined      = rsp_undef_ff;
   assign rsp_chan.good_total_out = rsp_good_ff;
   assign rsp_chan.same_total_out = rsp_same_ff;

   // Totals hold still while the divider reads them
   a_div_totals_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mar_pkg::ST_DIV) |=>
         ($stable(good_total_ff) && $stable(same_total_ff)))
      else $error("totals changed during division");

   // Same total is bounded by good total, good total by the limit
   a_totals_order: assert property (@(posedge clock) disable iff (reset)
      (same_total_ff <= good_total_ff) && (good_total_ff <= mar_pkg::TOTAL_LIMIT))
      else $error("totals out of order or past the limit");

   // A delivered ratio never exceeds one
   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sim_ff <= mar_pkg::RATIO_ONE))
      else $error("similarity above one");

   // An undefined result carries a zero good total and zero similarity
   a_undef_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_undef_ff) |-> ((rsp_sim_ff == '0) && (rsp_good_ff == '0)))
      else $error("undefined result with nonzero fields");

   // A new result is loaded only after the divider has run
   a_load_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mar_pkg::ST_DONE) |-> ($past(state_ff) == mar_pkg::ST_DIV ||
                                          $past(state_ff) == mar_pkg::ST_DONE))
      else $error("result stage entered without division");

endmodule : masked_agreement_ratio

`default_nettype wire
